// ----- hdl/hrp_pkg.sv -----
// Shared constants, types and the half-float decode for the half RGB to P010 quad converter.
package hrp_pkg;

  localparam int unsigned CODE_W   = 10;
  localparam int unsigned CODE_MAX = 1023;

  // Components are U1.24, so 1.0 needs a 25th bit
  localparam int unsigned COMP_W = 25;
  localparam logic [COMP_W-1:0] COMP_ONE = COMP_W'(1) << 24;

  // BT.2020 luma weights over 10000
  localparam int unsigned W_RED   = 2627;
  localparam int unsigned W_GREEN = 6780;
  localparam int unsigned W_BLUE  = 593;
  localparam int unsigned W_TOTAL = 10000;

  // Weighted sums (Y times 10000 in units of 2^-24)
  localparam int unsigned Y_W = 38;
  localparam int unsigned DIFF_W = Y_W + 1;
  localparam int unsigned SUM_W = DIFF_W + 2;

  // Luma: (219*Y + 1250*2^24) >> 22, then divide by 10000 and add 64
  localparam int unsigned LNUM_W   = 46;
  localparam int unsigned LUMA_MUL = 219;
  localparam logic [LNUM_W-1:0] LUMA_BIAS = LNUM_W'(1250) << 24;
  localparam int unsigned LUMA_SH  = 22;
  localparam int unsigned LQ_W     = LNUM_W - LUMA_SH;
  localparam int unsigned LUMA_DIV = W_TOTAL;
  localparam int unsigned LUMA_OFFSET = 64;

  // Chroma: (7*sum + 1025*(div/2)*2^19) >> 19, then divide by div
  localparam int unsigned CNUM_W    = 45;
  localparam int unsigned CHROMA_MUL = 7;
  localparam int unsigned CHROMA_SH = 19;
  localparam int unsigned CQ_W      = 25;
  localparam int unsigned CB_DIV    = 18814;
  localparam int unsigned CR_DIV    = 14746;
  localparam logic signed [CNUM_W-1:0] CB_BIAS =
    CNUM_W'(1025 * (CB_DIV / 2)) << CHROMA_SH;
  localparam logic signed [CNUM_W-1:0] CR_BIAS =
    CNUM_W'(1025 * (CR_DIV / 2)) << CHROMA_SH;

  // Stage enables for the two divider stages
  typedef struct packed {
    logic est;
    logic fix;
  } div_ctl_t;

  // Binary16 code to U1.24 clamped to [0,1]; NaN and negatives give 0
  function automatic logic [COMP_W-1:0] decode_half(input logic [15:0] code);
    logic             sgn;
    logic [4:0]       ex;
    logic [9:0]       man;
    logic [COMP_W-1:0] res;
    sgn = code[15];
    ex  = code[14:10];
    man = code[9:0];
    if (ex == 5'd31) begin
      res = (man == 10'd0 && !sgn) ? COMP_ONE : '0;
    end else if (sgn) begin
      res = '0;
    end else if (ex == 5'd0) begin
      res = COMP_W'(man);
    end else if (ex >= 5'd15) begin
      res = COMP_ONE;
    end else begin
      res = COMP_W'({1'b1, man}) << (ex - 5'd1);
    end
    return res;
  endfunction

endpackage

// ----- hdl/hrp_qdiv.sv -----
// Two-stage quantizer: offset plus floor of a value over a constant, saturated to a code.
module hrp_qdiv #(
  parameter int unsigned QW     = hrp_pkg::LQ_W,
  parameter int unsigned DIV    = hrp_pkg::LUMA_DIV,
  parameter int unsigned OFFSET = hrp_pkg::LUMA_OFFSET
) (
  input  logic                       clk,
  input  hrp_pkg::div_ctl_t          ctl,
  input  logic [QW-1:0]              num,
  output logic [hrp_pkg::CODE_W-1:0] code
);

  localparam int unsigned K_SH   = QW + 1;
  localparam longint unsigned RECIP = (64'd1 << K_SH) / DIV;
  localparam int unsigned MW     = $clog2(RECIP + 1);
  localparam int unsigned QUOT_W = $clog2((64'd1 << QW) / DIV + 1);
  localparam int unsigned OFS_W  = $clog2(OFFSET + 1);
  localparam int unsigned ACC_W  = ((OFS_W > QUOT_W) ? OFS_W : QUOT_W) + 1;

  logic [QW+MW-1:0]             prod;
  logic [QUOT_W-1:0]            est_nxt;
  logic [QUOT_W-1:0]            est_r;
  logic [QW-1:0]                num_r;
  logic [QW-1:0]                back;
  logic [QW-1:0]                rem;
  logic [QUOT_W-1:0]            quot;
  logic [ACC_W-1:0]             acc;
  logic [hrp_pkg::CODE_W-1:0]   code_nxt;
  logic [hrp_pkg::CODE_W-1:0]   code_r;

  // Reciprocal estimate is low by at most one
  assign prod    = (QW+MW)'(num) * (QW+MW)'(RECIP);
  assign est_nxt = QUOT_W'(prod >> K_SH);

  always_ff @(posedge clk) begin
    if (ctl.est) begin
      est_r <= est_nxt;
      num_r <= num;
    end
  end

  assign back = QW'(est_r) * QW'(DIV);
  assign rem  = num_r - back;
  assign quot = est_r + QUOT_W'(rem >= QW'(DIV));
  assign acc  = ACC_W'(quot) + ACC_W'(OFFSET);
  assign code_nxt = (acc > ACC_W'(hrp_pkg::CODE_MAX)) ?
                    hrp_pkg::CODE_W'(hrp_pkg::CODE_MAX) : acc[hrp_pkg::CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.fix) begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

endmodule

// ----- hdl/half_rgb_to_p010_quad.sv -----
// Top level: 2x2 half-float RGB quad to four BT.2020 limited-range luma codes and one Cb/Cr pair.
// Takes one quad per clock unless stalled with every stage full; quads pass a seven-stage
// pipeline (decode, weighted sums, luma scaling and color differences, quad sums, chroma
// scaling, then a two-stage reciprocal divider per output); the last stage is the output
// register. A stall on the output holds only the stages that are full, so bubbles close up
// and the input keeps taking quads while a result waits, until every stage holds a quad.
// Reset clears the stage valid bits.
module half_rgb_to_p010_quad (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_red_top_left,
  input  logic [15:0]                in_green_top_left,
  input  logic [15:0]                in_blue_top_left,
  input  logic [15:0]                in_red_top_right,
  input  logic [15:0]                in_green_top_right,
  input  logic [15:0]                in_blue_top_right,
  input  logic [15:0]                in_red_bottom_left,
  input  logic [15:0]                in_green_bottom_left,
  input  logic [15:0]                in_blue_bottom_left,
  input  logic [15:0]                in_red_bottom_right,
  input  logic [15:0]                in_green_bottom_right,
  input  logic [15:0]                in_blue_bottom_right,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hrp_pkg::CODE_W-1:0] out_luma_top_left,
  output logic [hrp_pkg::CODE_W-1:0] out_luma_top_right,
  output logic [hrp_pkg::CODE_W-1:0] out_luma_bottom_left,
  output logic [hrp_pkg::CODE_W-1:0] out_luma_bottom_right,
  output logic [hrp_pkg::CODE_W-1:0] out_chroma_blue,
  output logic [hrp_pkg::CODE_W-1:0] out_chroma_red
);

  localparam int unsigned NSTG = 7;

  logic [NSTG:1]   vld_r;
  logic [NSTG+1:1] adv;

  logic [15:0] in_red [4];
  logic [15:0] in_grn [4];
  logic [15:0] in_blu [4];

  logic [hrp_pkg::COMP_W-1:0] red_r [4];
  logic [hrp_pkg::COMP_W-1:0] grn_r [4];
  logic [hrp_pkg::COMP_W-1:0] blu_r [4];

  logic [hrp_pkg::Y_W-1:0] y_nxt  [4];
  logic [hrp_pkg::Y_W-1:0] y_r    [4];
  logic [hrp_pkg::Y_W-1:0] rw_r   [4];
  logic [hrp_pkg::Y_W-1:0] bw_r   [4];

  logic [hrp_pkg::LNUM_W-1:0]        lnum [4];
  logic [hrp_pkg::LQ_W-1:0]          lq3_r [4];
  logic signed [hrp_pkg::DIFF_W-1:0] db_r [4];
  logic signed [hrp_pkg::DIFF_W-1:0] dr_r [4];

  logic [hrp_pkg::LQ_W-1:0]         lq4_r [4];
  logic signed [hrp_pkg::SUM_W-1:0] sb_nxt;
  logic signed [hrp_pkg::SUM_W-1:0] sr_nxt;
  logic signed [hrp_pkg::SUM_W-1:0] sb_r;
  logic signed [hrp_pkg::SUM_W-1:0] sr_r;

  logic [hrp_pkg::LQ_W-1:0]          lq5_r [4];
  logic signed [hrp_pkg::CNUM_W-1:0] tb;
  logic signed [hrp_pkg::CNUM_W-1:0] tr;
  logic [hrp_pkg::CQ_W-1:0]          cbq_r;
  logic [hrp_pkg::CQ_W-1:0]          crq_r;

  logic [hrp_pkg::CODE_W-1:0] luma [4];
  hrp_pkg::div_ctl_t          dctl;

  assign in_red[0] = in_red_top_left;
  assign in_grn[0] = in_green_top_left;
  assign in_blu[0] = in_blue_top_left;
  assign in_red[1] = in_red_top_right;
  assign in_grn[1] = in_green_top_right;
  assign in_blu[1] = in_blue_top_right;
  assign in_red[2] = in_red_bottom_left;
  assign in_grn[2] = in_green_bottom_left;
  assign in_blu[2] = in_blue_bottom_left;
  assign in_red[3] = in_red_bottom_right;
  assign in_grn[3] = in_green_bottom_right;
  assign in_blu[3] = in_blue_bottom_right;

  // A stage advances when it is empty or the next one advances
  always_comb begin
    adv[NSTG+1] = out_ready;
    for (int i = NSTG; i >= 1; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 1: decode and clamp
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int p = 0; p < 4; p++) begin
        red_r[p] <= hrp_pkg::decode_half(in_red[p]);
        grn_r[p] <= hrp_pkg::decode_half(in_grn[p]);
        blu_r[p] <= hrp_pkg::decode_half(in_blu[p]);
      end
    end
  end

  // Stage 2: weighted luma sum and the scaled red and blue
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      y_nxt[p] = hrp_pkg::Y_W'(red_r[p]) * hrp_pkg::Y_W'(hrp_pkg::W_RED)
               + hrp_pkg::Y_W'(grn_r[p]) * hrp_pkg::Y_W'(hrp_pkg::W_GREEN)
               + hrp_pkg::Y_W'(blu_r[p]) * hrp_pkg::Y_W'(hrp_pkg::W_BLUE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int p = 0; p < 4; p++) begin
        y_r[p]  <= y_nxt[p];
        rw_r[p] <= hrp_pkg::Y_W'(red_r[p]) * hrp_pkg::Y_W'(hrp_pkg::W_TOTAL);
        bw_r[p] <= hrp_pkg::Y_W'(blu_r[p]) * hrp_pkg::Y_W'(hrp_pkg::W_TOTAL);
      end
    end
  end

  // Stage 3: luma numerator and color differences
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      lnum[p] = hrp_pkg::LNUM_W'(y_r[p]) * hrp_pkg::LNUM_W'(hrp_pkg::LUMA_MUL)
              + hrp_pkg::LUMA_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int p = 0; p < 4; p++) begin
        lq3_r[p] <= lnum[p][hrp_pkg::LNUM_W-1:hrp_pkg::LUMA_SH];
        db_r[p]  <= signed'({1'b0, bw_r[p]}) - signed'({1'b0, y_r[p]});
        dr_r[p]  <= signed'({1'b0, rw_r[p]}) - signed'({1'b0, y_r[p]});
      end
    end
  end

  // Stage 4: sum differences over the quad
  always_comb begin
    sb_nxt = '0;
    sr_nxt = '0;
    for (int p = 0; p < 4; p++) begin
      sb_nxt = sb_nxt + hrp_pkg::SUM_W'(db_r[p]);
      sr_nxt = sr_nxt + hrp_pkg::SUM_W'(dr_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      lq4_r <= lq3_r;
      sb_r  <= sb_nxt;
      sr_r  <= sr_nxt;
    end
  end

  // Stage 5: chroma numerators; always positive after the bias
  assign tb = hrp_pkg::CNUM_W'(sb_r) * hrp_pkg::CNUM_W'(hrp_pkg::CHROMA_MUL) + hrp_pkg::CB_BIAS;
  assign tr = hrp_pkg::CNUM_W'(sr_r) * hrp_pkg::CNUM_W'(hrp_pkg::CHROMA_MUL) + hrp_pkg::CR_BIAS;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      lq5_r <= lq4_r;
      cbq_r <= tb[hrp_pkg::CQ_W+hrp_pkg::CHROMA_SH-1:hrp_pkg::CHROMA_SH];
      crq_r <= tr[hrp_pkg::CQ_W+hrp_pkg::CHROMA_SH-1:hrp_pkg::CHROMA_SH];
    end
  end

  // Stages 6 and 7: divide by constant and quantize
  assign dctl.est = adv[6];
  assign dctl.fix = adv[7];

  for (genvar p = 0; p < 4; p++) begin : g_luma
    hrp_qdiv #(
      .QW     (hrp_pkg::LQ_W),
      .DIV    (hrp_pkg::LUMA_DIV),
      .OFFSET (hrp_pkg::LUMA_OFFSET)
    ) u_div (
      .clk  (clk),
      .ctl  (dctl),
      .num  (lq5_r[p]),
      .code (luma[p])
    );
  end

  hrp_qdiv #(
    .QW     (hrp_pkg::CQ_W),
    .DIV    (hrp_pkg::CB_DIV),
    .OFFSET (0)
  ) u_div_cb (
    .clk  (clk),
    .ctl  (dctl),
    .num  (cbq_r),
    .code (out_chroma_blue)
  );

  hrp_qdiv #(
    .QW     (hrp_pkg::CQ_W),
    .DIV    (hrp_pkg::CR_DIV),
    .OFFSET (0)
  ) u_div_cr (
    .clk  (clk),
    .ctl  (dctl),
    .num  (crq_r),
    .code (out_chroma_red)
  );

  assign out_luma_top_left     = luma[0];
  assign out_luma_top_right    = luma[1];
  assign out_luma_bottom_left  = luma[2];
  assign out_luma_bottom_right = luma[3];

endmodule
